// File: sv/bitv_pkg.sv
package bitv_pkg;

   localparam int unsigned MAX_INFO_BYTES_DEF = 1048576;
   localparam logic [31:0] BOOT_MAGIC_VALUE   = 32'h36d76289;
   localparam logic [31:0] TAG_END            = 32'd0;
   localparam logic [31:0] TAG_MMAP           = 32'd6;
   localparam logic [31:0] TAG_FRAMEBUFFER    = 32'd8;
   localparam logic [31:0] MAP_MIN_ENTRY      = 32'd24;
   localparam logic [31:0] FB_MIN_SIZE        = 32'd32;
   localparam logic [7:0]  FB_BPP_REQ         = 8'd32;
   localparam logic [7:0]  FB_TYPE_RGB        = 8'd1;

   localparam logic CSR_BOOT_MAGIC   = 1'b0;
   localparam logic CSR_INFO_ADDRESS = 1'b1;

   localparam logic [3:0] ERR_OK         = 4'd0;
   localparam logic [3:0] ERR_MAGIC      = 4'd1;
   localparam logic [3:0] ERR_ALIGN      = 4'd2;
   localparam logic [3:0] ERR_TOTAL_SIZE = 4'd3;
   localparam logic [3:0] ERR_SHORT_HDR  = 4'd4;
   localparam logic [3:0] ERR_TAG_SIZE   = 4'd5;
   localparam logic [3:0] ERR_END_SIZE   = 4'd6;
   localparam logic [3:0] ERR_NO_MAP     = 4'd7;
   localparam logic [3:0] ERR_BAD_MAP    = 4'd8;
   localparam logic [3:0] ERR_PADDING    = 4'd9;
   localparam logic [3:0] ERR_NO_END     = 4'd10;

   typedef struct packed {
      logic [31:0] word;
      logic        start_req;
   } req_type;

   typedef struct packed {
      logic        ok;
      logic [3:0]  error_code;
      logic [20:0] total_size;
      logic [20:0] mmap_offset;
      logic [20:0] mmap_entry_size;
      logic [20:0] mmap_tag_size;
      logic        fb_valid;
      logic [63:0] fb_address;
      logic [31:0] fb_pitch;
      logic [31:0] fb_width;
      logic [31:0] fb_height;
      logic [31:0] fb_bytes;
   } rsp_type;

   typedef struct packed {
      logic start;
      logic op_mul;
   } alu_ctrl_type;

endpackage

// File: sv/bitv_alu.sv
// Shared 32-step unit: restoring remainder (a mod b) or low-word product (a * b),
// one bit per cycle through a single 33-bit adder.
module bitv_alu (
   input  logic                  clock,
   input  logic                  reset,
   input  bitv_pkg::alu_ctrl_type ctrl,
   input  logic [31:0]           a,
   input  logic [31:0]           b,
   output logic                  busy,
   output logic                  done,
   output logic [31:0]           result
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic        mul_ff, mul_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [31:0] x_ff, x_in;
   logic [31:0] y_ff, y_in;
   logic [31:0] z_ff, z_in;
   logic [32:0] opx, opy;
   logic        sub;
   logic [33:0] sum;

   always_comb begin
      if (mul_ff) begin
         opx = {1'b0, x_ff};
         opy = y_ff[0] ? {1'b0, z_ff} : 33'd0;
         sub = 1'b0;
      end else begin
         opx = {x_ff, y_ff[31]};
         opy = {1'b0, z_ff};
         sub = 1'b1;
      end
      sum = {1'b0, opx} + {1'b0, (sub ? ~opy : opy)} + 34'(sub);
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      mul_in  = mul_ff;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      if (ctrl.start) begin
         busy_in = 1'b1;
         mul_in  = ctrl.op_mul;
         cnt_in  = 5'd0;
         x_in    = 32'd0;
         y_in    = ctrl.op_mul ? b : a;
         z_in    = ctrl.op_mul ? a : b;
      end else if (busy_ff) begin
         if (mul_ff) begin
            x_in = sum[31:0];
            y_in = {1'b0, y_ff[31:1]};
            z_in = {z_ff[30:0], 1'b0};
         end else begin
            // A carry out means the shifted remainder was not below the divisor.
            x_in = sum[33] ? sum[31:0] : opx[31:0];
            y_in = {y_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         mul_ff  <= 1'b0;
         cnt_ff  <= 5'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         mul_ff  <= mul_in;
         cnt_ff  <= cnt_in;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign busy   = busy_ff;
   assign done   = done_ff;
   assign result = x_ff;

endmodule

// File: sv/boot_info_tag_validator.sv
// Boot information tag validator. Words of the structure are taken one per cycle while
// req_ready is high, a start word first. One verdict word comes out at the end tag or
// at the first error. The fourth word of the first memory-map tag and the eighth word
// of the first usable framebuffer tag each start a run on the shared 32-step
// remainder/multiply unit, during which req_ready is low. A pending verdict word also
// holds req_ready low until it is taken.
module boot_info_tag_validator #(
   parameter int unsigned MAX_INFO_BYTES = bitv_pkg::MAX_INFO_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bitv_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bitv_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [31:0]       csr_wdata
);

   localparam int unsigned SW = $clog2(MAX_INFO_BYTES + 1) + 1;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_RUN  = 4'b0010,
      ST_MOD  = 4'b0100,
      ST_MUL  = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [31:0]       magic_ff, addr_ff;
   logic [SW-1:0]     size_ff, size_in;
   logic [20:0]       total_ff, total_in;
   logic [SW-1:0]     pos_ff, pos_in;
   logic [SW-1:0]     ts_ff, ts_in;
   logic [31:0]       hdr_ff [8];
   logic [31:0]       hdr_in [8];
   logic              map_found_ff, map_found_in;
   logic [SW-1:0]     map_off_ff, map_off_in;
   logic [31:0]       map_es_ff, map_es_in;
   logic [31:0]       map_sz_ff, map_sz_in;
   logic              fb_found_ff, fb_found_in;
   logic [63:0]       fb_addr_ff, fb_addr_in;
   logic [31:0]       fb_pitch_ff, fb_pitch_in;
   logic [31:0]       fb_width_ff, fb_width_in;
   logic [31:0]       fb_height_ff, fb_height_in;
   logic [7:0]        fb_bpp_ff, fb_bpp_in;
   logic [7:0]        fb_kind_ff, fb_kind_in;
   logic [31:0]       fb_bytes_ff, fb_bytes_in;
   logic              rsp_valid_ff, rsp_valid_in;
   bitv_pkg::rsp_type rsp_ff, rsp_in;

   bitv_pkg::alu_ctrl_type alu_ctrl;
   logic [31:0]       alu_a, alu_b, alu_result;
   logic              alu_busy, alu_done;

   logic              accept;
   logic              emit;
   logic [3:0]        emit_err;
   logic [20:0]       emit_total;

   logic [SW-1:0]     off, diff, ts_e, diff_e;
   logic [33:0]       cur_end;
   logic              kvalid;
   logic [2:0]        k;
   logic [31:0]       type_e, sz_e, es;
   logic [3:0]        cerr;
   logic [32:0]       wrap_sum;

   function automatic logic [32:0] round8(input logic [31:0] v);
      logic [32:0] t;
      t = {1'b0, v} + 33'd7;
      return {t[32:3], 3'b000};
   endfunction

   // Padding check of a tag and checks on where the next tag starts.
   function automatic logic [3:0] close_err(input logic [31:0] sz, input logic [SW-1:0] ts,
                                            input logic [SW-1:0] size);
      logic [32:0] rnd;
      logic [33:0] nxt;
      rnd = round8(sz);
      nxt = 34'(ts) + 34'(rnd);
      if (rnd > 33'(size - ts))             return bitv_pkg::ERR_PADDING;
      if (nxt >= 34'(size))                 return bitv_pkg::ERR_NO_END;
      if ((34'(size) - nxt) < 34'd8)        return bitv_pkg::ERR_SHORT_HDR;
      return bitv_pkg::ERR_OK;
   endfunction

   assign req_ready = (state_ff == ST_IDLE || state_ff == ST_RUN) &&
                      (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in     = state_ff;
      size_in      = size_ff;
      total_in     = total_ff;
      pos_in       = pos_ff;
      ts_in        = ts_ff;
      hdr_in       = hdr_ff;
      map_found_in = map_found_ff;
      map_off_in   = map_off_ff;
      map_es_in    = map_es_ff;
      map_sz_in    = map_sz_ff;
      fb_found_in  = fb_found_ff;
      fb_addr_in   = fb_addr_ff;
      fb_pitch_in  = fb_pitch_ff;
      fb_width_in  = fb_width_ff;
      fb_height_in = fb_height_ff;
      fb_bpp_in    = fb_bpp_ff;
      fb_kind_in   = fb_kind_ff;
      fb_bytes_in  = fb_bytes_ff;
      emit         = 1'b0;
      emit_err     = bitv_pkg::ERR_OK;
      emit_total   = total_ff;
      alu_ctrl     = '0;
      alu_a        = hdr_ff[1] - 32'd16;
      alu_b        = hdr_ff[2];

      off      = pos_ff;
      diff     = off - ts_ff;
      cur_end  = 34'(ts_ff) + 34'(round8(hdr_ff[1]));
      ts_e     = (diff >= SW'(8) && 34'(off) == cur_end) ? off : ts_ff;
      diff_e   = off - ts_e;
      kvalid   = diff_e < SW'(32);
      k        = diff_e[4:2];
      type_e   = (kvalid && k == 3'd0) ? req_data.word : hdr_ff[0];
      sz_e     = (kvalid && k == 3'd1) ? req_data.word : hdr_ff[1];
      es       = hdr_ff[2];
      cerr     = close_err(sz_e, ts_e, size_ff);
      wrap_sum = {1'b0, addr_ff} + {1'b0, req_data.word};

      if (accept && req_data.start_req) begin
         state_in     = ST_RUN;
         size_in      = '0;
         total_in     = '0;
         pos_in       = '0;
         ts_in        = '0;
         map_found_in = 1'b0;
         map_off_in   = '0;
         map_es_in    = '0;
         map_sz_in    = '0;
         fb_found_in  = 1'b0;
         emit_total   = '0;
         if (magic_ff != bitv_pkg::BOOT_MAGIC_VALUE) begin
            emit = 1'b1; emit_err = bitv_pkg::ERR_MAGIC;
         end else if (addr_ff[2:0] != 3'd0) begin
            emit = 1'b1; emit_err = bitv_pkg::ERR_ALIGN;
         end else begin
            total_in   = req_data.word[20:0];
            emit_total = req_data.word[20:0];
            if (req_data.word < 32'd16 || req_data.word > 32'(MAX_INFO_BYTES) ||
                wrap_sum[32]) begin
               emit = 1'b1; emit_err = bitv_pkg::ERR_TOTAL_SIZE;
            end else begin
               size_in = SW'(req_data.word);
               pos_in  = SW'(4);
               ts_in   = SW'(8);
            end
         end
      end else if (accept && state_ff == ST_RUN) begin
         pos_in = pos_ff + SW'(4);
         if (off >= SW'(8)) begin
            ts_in = ts_e;
            if (kvalid) hdr_in[k] = req_data.word;
            if (kvalid && k == 3'd1) begin
               if (sz_e < 32'd8 || 33'(sz_e) > 33'(size_ff - ts_e)) begin
                  emit = 1'b1; emit_err = bitv_pkg::ERR_TAG_SIZE;
               end else if (type_e == bitv_pkg::TAG_END) begin
                  emit = 1'b1;
                  if (sz_e != 32'd8)      emit_err = bitv_pkg::ERR_END_SIZE;
                  else if (!map_found_ff) emit_err = bitv_pkg::ERR_NO_MAP;
                  else                    emit_err = bitv_pkg::ERR_OK;
               end else if (type_e == bitv_pkg::TAG_MMAP && !map_found_ff) begin
                  if (sz_e < 32'd16) begin
                     emit = 1'b1; emit_err = bitv_pkg::ERR_BAD_MAP;
                  end
               end else if (cerr != bitv_pkg::ERR_OK) begin
                  emit = 1'b1; emit_err = cerr;
               end
            end else if (kvalid && k == 3'd3 && type_e == bitv_pkg::TAG_MMAP &&
                         !map_found_ff) begin
               if (req_data.word != 32'd0 || es < bitv_pkg::MAP_MIN_ENTRY ||
                   es[2:0] != 3'd0) begin
                  emit = 1'b1; emit_err = bitv_pkg::ERR_BAD_MAP;
               end else begin
                  // The divisibility check runs on the shared unit.
                  alu_ctrl.start = 1'b1;
                  state_in       = ST_MOD;
               end
            end else if (kvalid && k == 3'd7 && type_e == bitv_pkg::TAG_FRAMEBUFFER &&
                         !fb_found_ff && sz_e >= bitv_pkg::FB_MIN_SIZE) begin
               if ({hdr_ff[3], hdr_ff[2]} != 64'd0 && hdr_ff[4] != 32'd0 &&
                   hdr_ff[5] != 32'd0 && hdr_ff[6] != 32'd0) begin
                  fb_found_in     = 1'b1;
                  fb_addr_in      = {hdr_ff[3], hdr_ff[2]};
                  fb_pitch_in     = hdr_ff[4];
                  fb_width_in     = hdr_ff[5];
                  fb_height_in    = hdr_ff[6];
                  fb_bpp_in       = req_data.word[7:0];
                  fb_kind_in      = req_data.word[15:8];
                  alu_ctrl.start  = 1'b1;
                  alu_ctrl.op_mul = 1'b1;
                  alu_a           = hdr_ff[4];
                  alu_b           = hdr_ff[6];
                  state_in        = ST_MUL;
               end
            end
         end
      end else if (state_ff == ST_MOD && alu_done) begin
         state_in = ST_RUN;
         if (alu_result != 32'd0) begin
            emit = 1'b1; emit_err = bitv_pkg::ERR_BAD_MAP;
         end else begin
            map_found_in = 1'b1;
            map_off_in   = ts_ff;
            map_es_in    = hdr_ff[2];
            map_sz_in    = hdr_ff[1];
            cerr         = close_err(hdr_ff[1], ts_ff, size_ff);
            if (cerr != bitv_pkg::ERR_OK) begin
               emit = 1'b1; emit_err = cerr;
            end
         end
      end else if (state_ff == ST_MUL && alu_done) begin
         state_in    = ST_RUN;
         fb_bytes_in = alu_result;
      end

      if (emit) state_in = ST_IDLE;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if (emit) begin
         rsp_valid_in       = 1'b1;
         rsp_in             = '0;
         rsp_in.ok          = (emit_err == bitv_pkg::ERR_OK);
         rsp_in.error_code  = emit_err;
         rsp_in.total_size  = emit_total;
         if (emit_err == bitv_pkg::ERR_OK) begin
            rsp_in.mmap_offset     = 21'(map_off_ff);
            rsp_in.mmap_entry_size = map_es_ff[20:0];
            rsp_in.mmap_tag_size   = map_sz_ff[20:0];
            if (fb_found_ff && fb_bpp_ff == bitv_pkg::FB_BPP_REQ &&
                fb_kind_ff == bitv_pkg::FB_TYPE_RGB) begin
               rsp_in.fb_valid   = 1'b1;
               rsp_in.fb_address = fb_addr_ff;
               rsp_in.fb_pitch   = fb_pitch_ff;
               rsp_in.fb_width   = fb_width_ff;
               rsp_in.fb_height  = fb_height_ff;
               rsp_in.fb_bytes   = fb_bytes_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         magic_ff     <= '0;
         addr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         map_found_ff <= 1'b0;
         fb_found_ff  <= 1'b0;
         size_ff      <= '0;
         total_ff     <= '0;
         pos_ff       <= '0;
         ts_ff        <= '0;
         map_off_ff   <= '0;
         map_es_ff    <= '0;
         map_sz_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         map_found_ff <= map_found_in;
         fb_found_ff  <= fb_found_in;
         size_ff      <= size_in;
         total_ff     <= total_in;
         pos_ff       <= pos_in;
         ts_ff        <= ts_in;
         map_off_ff   <= map_off_in;
         map_es_ff    <= map_es_in;
         map_sz_ff    <= map_sz_in;
         if (csr_we) begin
            case (csr_index)
               bitv_pkg::CSR_BOOT_MAGIC:   magic_ff <= csr_wdata;
               bitv_pkg::CSR_INFO_ADDRESS: addr_ff  <= csr_wdata;
               default: ;
            endcase
         end
      end
      hdr_ff       <= hdr_in;
      fb_addr_ff   <= fb_addr_in;
      fb_pitch_ff  <= fb_pitch_in;
      fb_width_ff  <= fb_width_in;
      fb_height_ff <= fb_height_in;
      fb_bpp_ff    <= fb_bpp_in;
      fb_kind_ff   <= fb_kind_in;
      fb_bytes_ff  <= fb_bytes_in;
      rsp_ff       <= rsp_in;
   end

   bitv_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (alu_ctrl),
      .a      (alu_a),
      .b      (alu_b),
      .busy   (alu_busy),
      .done   (alu_done),
      .result (alu_result)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MOD || state_ff == ST_MUL) |-> !req_ready)
      else $error("input taken while the shared unit is busy");

   a_alu_matches_state: assert property (@(posedge clock) disable iff (reset)
      alu_busy |-> (state_ff == ST_MOD || state_ff == ST_MUL))
      else $error("shared unit running outside a wait state");

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      alu_done |-> (state_ff == ST_MOD || state_ff == ST_MUL))
      else $error("shared unit finished with nobody waiting");

   a_ok_code: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.ok) |-> (rsp_ff.error_code == bitv_pkg::ERR_OK))
      else $error("accepted verdict carries an error code");

endmodule
